[rtl/core/sfr_pkg.sv]
package sfr_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int MAX_REPLACE_DEF = 16;
	localparam int LEN_CAP         = 16;
	localparam int CNT_W           = 5;
	localparam int ADDR_W          = 6;
	localparam int DATA_W          = 64;

	typedef enum logic [2:0] {
		REG_PATTERN_LEN  = 3'd0,
		REG_PATTERN_LOW  = 3'd1,
		REG_PATTERN_HIGH = 3'd2,
		REG_REPLACE_LEN  = 3'd3,
		REG_REPLACE_LOW  = 3'd4,
		REG_REPLACE_HIGH = 3'd5
	} sfr_reg_t;

	typedef struct packed {
		logic [CNT_W-1:0]           plen;
		logic [CNT_W-1:0]           rlen;
		logic [LEN_CAP-1:0][7:0]    pat;
		logic [LEN_CAP-1:0][7:0]    rep;
	} sfr_cfg_t;

	typedef struct packed {
		logic             repl;
		logic             term;
		logic [CNT_W-1:0] n;
	} sfr_job_t;

endpackage

[rtl/core/sfr_cfg_regs.sv]
module sfr_cfg_regs #(
	parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF,
	parameter int MAX_REPLACE = sfr_pkg::MAX_REPLACE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sfr_pkg::ADDR_W-1:0]  paddr,
	input  logic [sfr_pkg::DATA_W-1:0]  pwdata,
	output logic [sfr_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output sfr_pkg::sfr_cfg_t           cfg,
	output logic                        clr_win
);
	import sfr_pkg::*;

	localparam int PTOP = (MAX_PATTERN < LEN_CAP) ? MAX_PATTERN : LEN_CAP;
	localparam int RTOP = (MAX_REPLACE < LEN_CAP) ? MAX_REPLACE : LEN_CAP;

	logic [CNT_W-1:0]  plen_q;
	logic [CNT_W-1:0]  rlen_q;
	logic [DATA_W-1:0] pat_lo_q;
	logic [DATA_W-1:0] pat_hi_q;
	logic [DATA_W-1:0] rep_lo_q;
	logic [DATA_W-1:0] rep_hi_q;
	logic              wr;
	sfr_reg_t          sel;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign sel    = sfr_reg_t'(paddr[ADDR_W-1:3]);
	assign clr_win = wr && (sel == REG_PATTERN_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q   <= CNT_W'(1);
			rlen_q   <= '0;
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			rep_lo_q <= '0;
			rep_hi_q <= '0;
		end else if (wr) begin
			unique case (sel)
				REG_PATTERN_LEN:  plen_q   <= pwdata[CNT_W-1:0];
				REG_PATTERN_LOW:  pat_lo_q <= pwdata;
				REG_PATTERN_HIGH: pat_hi_q <= pwdata;
				REG_REPLACE_LEN:  rlen_q   <= pwdata[CNT_W-1:0];
				REG_REPLACE_LOW:  rep_lo_q <= pwdata;
				REG_REPLACE_HIGH: rep_hi_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_PATTERN_LEN:  prdata = DATA_W'(plen_q);
			REG_PATTERN_LOW:  prdata = pat_lo_q;
			REG_PATTERN_HIGH: prdata = pat_hi_q;
			REG_REPLACE_LEN:  prdata = DATA_W'(rlen_q);
			REG_REPLACE_LOW:  prdata = rep_lo_q;
			REG_REPLACE_HIGH: prdata = rep_hi_q;
			default:          prdata = '0;
		endcase
	end

	always_comb begin
		cfg.plen = plen_q;
		if (plen_q == '0)
			cfg.plen = CNT_W'(1);
		else if (plen_q > CNT_W'(PTOP))
			cfg.plen = CNT_W'(PTOP);
		cfg.rlen = (rlen_q > CNT_W'(RTOP)) ? CNT_W'(RTOP) : rlen_q;
		cfg.pat  = {pat_hi_q, pat_lo_q};
		cfg.rep  = {rep_hi_q, rep_lo_q};
	end

endmodule

[rtl/core/sfr_window.sv]
module sfr_window #(
	parameter int WIN = sfr_pkg::LEN_CAP
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             in_byte,
	input  logic                   byte_present,
	input  logic                   string_done,
	input  sfr_pkg::sfr_cfg_t      cfg,
	input  logic                   clr_win,
	input  logic                   job_free,
	output logic                   job_load,
	output sfr_pkg::sfr_job_t      job,
	output logic [WIN-1:0][7:0]    job_bytes
);
	import sfr_pkg::*;

	localparam int CW   = $clog2(WIN + 1);
	localparam int IDXW = (WIN > 1) ? $clog2(WIN) : 1;

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                present_s1;
	logic                done_s1;
	logic [WIN-1:0][7:0] win_q;
	logic [CW-1:0]       cnt_q;

	logic [WIN-1:0][7:0] nwin;
	logic [WIN-1:0][7:0] shwin;
	logic [CW-1:0]       ncnt;
	logic                full;
	logic                match;
	logic                has_job;
	logic                go;
	logic [WIN-1:0][7:0] win_d;
	logic [CW-1:0]       cnt_d;

	always_comb begin
		nwin = win_q;
		ncnt = cnt_q;
		if (present_s1 && (cnt_q < CW'(WIN))) begin
			nwin[cnt_q[IDXW-1:0]] = byte_s1;
			ncnt = cnt_q + CW'(1);
		end
		shwin = nwin;
		for (int i = 0; i < WIN - 1; i++)
			shwin[i] = nwin[i + 1];
		full  = present_s1 && (CNT_W'(ncnt) >= cfg.plen);
		match = 1'b1;
		for (int i = 0; i < WIN; i++)
			if ((CNT_W'(i) < cfg.plen) && (nwin[i] != cfg.pat[i]))
				match = 1'b0;
	end

	always_comb begin
		job.repl = 1'b0;
		job.term = done_s1;
		job.n    = '0;
		win_d    = nwin;
		cnt_d    = ncnt;
		if (full && match) begin
			job.repl = 1'b1;
			job.n    = cfg.rlen;
			cnt_d    = '0;
		end else if (full && !done_s1) begin
			job.n = CNT_W'(1);
			win_d = shwin;
			cnt_d = ncnt - CW'(1);
		end else if (done_s1) begin
			job.n = CNT_W'(ncnt);
			cnt_d = '0;
		end
		has_job = (job.n != '0) || done_s1;
	end

	assign job_bytes = nwin;
	assign go        = valid_s1 && (!has_job || job_free);
	assign job_load  = go && has_job;
	assign in_ready  = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (in_valid && in_ready)
				valid_s1 <= 1'b1;
			else if (go)
				valid_s1 <= 1'b0;
			if (clr_win)
				cnt_q <= '0;
			else if (go)
				cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1    <= in_byte;
			present_s1 <= byte_present;
			done_s1    <= string_done;
		end
		if (go)
			win_q <= win_d;
	end

endmodule

[rtl/core/sfr_emit.sv]
module sfr_emit #(
	parameter int WIN = sfr_pkg::LEN_CAP
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  job_load,
	input  sfr_pkg::sfr_job_t                     job,
	input  logic [WIN-1:0][7:0]                   job_bytes,
	input  logic [sfr_pkg::LEN_CAP-1:0][7:0]      rep,
	output logic                                  job_free,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [7:0]                            out_byte,
	output logic                                  out_present,
	output logic                                  run_end,
	output logic                                  output_done
);
	import sfr_pkg::*;

	localparam int IDXW = (WIN > 1) ? $clog2(WIN) : 1;

	logic                job_valid_q;
	sfr_job_t            job_q;
	logic [WIN-1:0][7:0] bytes_q;
	logic [CNT_W-1:0]    idx_q;
	logic                out_valid_q;

	logic                is_byte;
	logic [7:0]          cur_byte;
	logic                last;
	logic                out_load;

	always_comb begin
		is_byte  = idx_q < job_q.n;
		cur_byte = job_q.repl ? rep[idx_q[3:0]] : bytes_q[idx_q[IDXW-1:0]];
		last     = is_byte ? ((idx_q == job_q.n - CNT_W'(1)) && !job_q.term) : 1'b1;
	end

	assign out_load  = job_valid_q && (!out_valid_q || out_ready);
	assign job_free  = !job_valid_q || (out_load && last);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (job_load) begin
				job_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (out_load && last) begin
				job_valid_q <= 1'b0;
			end else if (out_load) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_load) begin
			job_q   <= job;
			bytes_q <= job_bytes;
		end
		if (out_load) begin
			out_byte    <= is_byte ? cur_byte : 8'd0;
			out_present <= is_byte;
			run_end     <= last;
			output_done <= !is_byte;
		end
	end

endmodule

[rtl/core/stream_find_replace_core.sv]
// Streaming find-and-replace over a byte string.
// Input words carry in_byte, byte_present and string_done on a valid/ready
// channel; output words carry out_byte, out_present, run_end and output_done.
// Every leftmost, non-overlapping match of the pattern is replaced by the
// replacement string; other bytes pass in order. A word with string_done
// flushes the held bytes and ends with a terminator word (output_done high).
// run_end marks the last output word caused by one input word.
// Pattern and replacement are set over the APB port (64-bit registers at
// byte address 8*i); the user must set them only while the block is idle,
// which the block itself does not enforce. Writing pattern_len drops any
// held bytes. The first output word of an input word passes the input
// register, the job register (job_q) and the output register when nothing
// is queued ahead of it. Words that cause zero or one output word go through
// at one per cycle while out_ready stays high; a word that causes k output
// words holds the output sequencer until all k are out, one word per cycle,
// and input waits behind it. When out_ready is low the output register holds
// its word, the sequencer and input register fill, and in_ready drops.
// Reset clears all valid flags, the held-byte count and the registers
// (pattern_len to 1, all others to 0).
module stream_find_replace_core #(
	parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF,
	parameter int MAX_REPLACE = sfr_pkg::MAX_REPLACE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sfr_pkg::ADDR_W-1:0]  paddr,
	input  logic [sfr_pkg::DATA_W-1:0]  pwdata,
	output logic [sfr_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  in_byte,
	input  logic                        byte_present,
	input  logic                        string_done,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  out_byte,
	output logic                        out_present,
	output logic                        run_end,
	output logic                        output_done
);
	import sfr_pkg::*;

	localparam int WIN = (MAX_PATTERN < LEN_CAP) ? MAX_PATTERN : LEN_CAP;

	sfr_cfg_t            cfg;
	logic                clr_win;
	logic                job_free;
	logic                job_load;
	sfr_job_t            job;
	logic [WIN-1:0][7:0] job_bytes;

	sfr_cfg_regs #(
		.MAX_PATTERN (MAX_PATTERN),
		.MAX_REPLACE (MAX_REPLACE)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.clr_win (clr_win)
	);

	sfr_window #(
		.WIN (WIN)
	) u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.byte_present (byte_present),
		.string_done  (string_done),
		.cfg          (cfg),
		.clr_win      (clr_win),
		.job_free     (job_free),
		.job_load     (job_load),
		.job          (job),
		.job_bytes    (job_bytes)
	);

	sfr_emit #(
		.WIN (WIN)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_load    (job_load),
		.job         (job),
		.job_bytes   (job_bytes),
		.rep         (cfg.rep),
		.job_free    (job_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.out_present (out_present),
		.run_end     (run_end),
		.output_done (output_done)
	);

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

typedef struct packed {
	logic [7:0] data;
	logic       present;
	logic       last;
	logic       done;
} out_word_t;

class replace_board;
	out_word_t   expected_words[$];
	logic [4:0]  pat_len;
	logic [4:0]  rep_len;
	logic [63:0] pat_lo;
	logic [63:0] pat_hi;
	logic [63:0] rep_lo;
	logic [63:0] rep_hi;
	logic [7:0]  window [sfr_pkg::LEN_CAP];
	int          held;
	int          errors;

	function new();
		pat_len = 5'd1;
		rep_len = 5'd0;
		pat_lo = '0;
		pat_hi = '0;
		rep_lo = '0;
		rep_hi = '0;
		foreach (window[i]) window[i] = 8'h00;
		held = 0;
		errors = 0;
	endfunction

	function int eff_plen();
		if (pat_len == 5'd0) return 1;
		if (pat_len > sfr_pkg::MAX_PATTERN_DEF) return sfr_pkg::MAX_PATTERN_DEF;
		return int'(pat_len);
	endfunction

	function int eff_rlen();
		if (rep_len > sfr_pkg::MAX_REPLACE_DEF) return sfr_pkg::MAX_REPLACE_DEF;
		return int'(rep_len);
	endfunction

	function logic [7:0] byte_at(logic [63:0] lo, logic [63:0] hi, int i);
		if (i < 8) return lo[8*i +: 8];
		return hi[8*(i-8) +: 8];
	endfunction

	function void write_reg(sfr_pkg::sfr_reg_t idx, logic [63:0] v);
		case (idx)
			sfr_pkg::REG_PATTERN_LEN: begin
				pat_len = v[4:0];
				held = 0;
			end
			sfr_pkg::REG_PATTERN_LOW:  pat_lo = v;
			sfr_pkg::REG_PATTERN_HIGH: pat_hi = v;
			sfr_pkg::REG_REPLACE_LEN:  rep_len = v[4:0];
			sfr_pkg::REG_REPLACE_LOW:  rep_lo = v;
			sfr_pkg::REG_REPLACE_HIGH: rep_hi = v;
			default: ;
		endcase
	endfunction

	function void note_input_word(logic [7:0] b, logic present, logic done);
		out_word_t batch[$];
		int        plen;
		int        rlen;
		bit        hit;
		plen = eff_plen();
		rlen = eff_rlen();
		if (present) begin
			if (held < sfr_pkg::MAX_PATTERN_DEF) begin
				window[held] = b;
				held++;
			end
			if (held >= plen) begin
				hit = 1'b1;
				for (int i = 0; i < plen; i++)
					if (window[i] != byte_at(pat_lo, pat_hi, i)) hit = 1'b0;
				if (hit) begin
					for (int i = 0; i < rlen; i++)
						batch.push_back(out_word_t'{byte_at(rep_lo, rep_hi, i), 1'b1, 1'b0, 1'b0});
					held = 0;
				end else begin
					batch.push_back(out_word_t'{window[0], 1'b1, 1'b0, 1'b0});
					for (int i = 1; i < held; i++) window[i-1] = window[i];
					held--;
				end
			end
		end
		if (done) begin
			for (int i = 0; i < held; i++)
				batch.push_back(out_word_t'{window[i], 1'b1, 1'b0, 1'b0});
			held = 0;
			batch.push_back(out_word_t'{8'h00, 1'b0, 1'b0, 1'b1});
		end
		if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
		foreach (batch[i]) expected_words.push_back(batch[i]);
	endfunction

	function void check_output_word(logic [7:0] b, logic present, logic last, logic done);
		out_word_t want;
		out_word_t got;
		got = {b, present, last, done};
		if (expected_words.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected output word: byte=%02h present=%0b run_end=%0b done=%0b",
					b, present, last, done);
			return;
		end
		want = expected_words.pop_front();
		if (got !== want) begin
			errors++;
			if (errors <= 10)
				$display({"word mismatch: expected byte=%02h present=%0b run_end=%0b done=%0b,",
					" got byte=%02h present=%0b run_end=%0b done=%0b"},
					want.data, want.present, want.last, want.done,
					got.data, got.present, got.last, got.done);
		end
	endfunction
endclass

module tb;
	import sfr_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_LEN       = 250;
	localparam int DRAIN_CYCLES   = 10;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_WORDS    = 50;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	logic [7:0]        in_byte;
	logic              byte_present;
	logic              string_done;
	logic              out_valid;
	logic              out_ready;
	logic [7:0]        out_byte;
	logic              out_present;
	logic              run_end;
	logic              output_done;

	replace_board board = new();
	bit           tx_idle;
	bit           rx_idle;
	bit           hold_req;

	stream_find_replace_core dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap(bit enabled);
		int r;
		if (!enabled) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic in_gap(int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic send_word(logic [7:0] b, logic present, logic done);
		@(negedge clk);
		in_valid <= 1'b1;
		in_byte <= b;
		byte_present <= present;
		string_done <= done;
		do @(posedge clk); while (!in_ready);
		in_gap(pick_gap(tx_idle));
	endtask

	task automatic apb_write(sfr_reg_t idx, logic [63:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.write_reg(idx, v);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_config(logic [4:0] plen, logic [15:0][7:0] pat,
			logic [4:0] rlen, logic [15:0][7:0] rep);
		apb_write(REG_PATTERN_LOW, pat[7:0]);
		apb_write(REG_PATTERN_HIGH, pat[15:8]);
		apb_write(REG_REPLACE_LEN, 64'(rlen));
		apb_write(REG_REPLACE_LOW, rep[7:0]);
		apb_write(REG_REPLACE_HIGH, rep[15:8]);
		apb_write(REG_PATTERN_LEN, 64'(plen));
	endtask

	task automatic settle();
		in_gap(1);
		while (board.expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : receiver
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_LEN;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				stall_left = pick_gap(rx_idle);
			end
		end
	end

	always @(posedge clk) begin
		if (in_valid && in_ready)
			board.note_input_word(in_byte, byte_present, string_done);
		if (out_valid && out_ready)
			board.check_output_word(out_byte, out_present, run_end, output_done);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		logic [15:0][7:0] pat;
		logic [15:0][7:0] rep;
		logic [7:0]       alpha [3];
		logic [4:0]       plen_w;
		logic [4:0]       rlen_w;
		int               plen;
		int               sent;
		int               r;
		int               n;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		byte_present = 1'b0;
		string_done = 1'b0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		hold_req = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		pat = '0;
		pat[0] = 8'h61;
		pat[1] = 8'h62;
		rep = '0;
		rep[0] = 8'h58;
		rep[1] = 8'h59;
		rep[2] = 8'h5a;
		load_config(5'd2, pat, 5'd3, rep);
		send_word(8'h61, 1'b1, 1'b0);
		send_word(8'h62, 1'b1, 1'b0);
		send_word(8'h00, 1'b1, 1'b0);
		send_word(8'hff, 1'b1, 1'b0);
		send_word(8'h61, 1'b1, 1'b0);
		send_word(8'h62, 1'b1, 1'b1);
		settle();

		pat = '0;
		rep = '1;
		load_config(5'd0, pat, 5'd0, rep);
		send_word(8'h00, 1'b1, 1'b0);
		send_word(8'h41, 1'b1, 1'b0);
		send_word(8'h7e, 1'b0, 1'b0);
		send_word(8'h5a, 1'b0, 1'b1);
		settle();

		for (int k = 0; k < 16; k++) begin
			pat[k] = 8'($urandom);
			rep[k] = 8'($urandom);
		end
		load_config(5'd31, pat, 5'd20, rep);
		for (int k = 0; k < 16; k++) send_word(pat[k], 1'b1, 1'b0);
		send_word(pat[0], 1'b1, 1'b0);
		settle();
		// drop the held byte mid-string
		apb_write(REG_PATTERN_LEN, 64'd3);
		send_word(8'h00, 1'b0, 1'b1);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			tx_idle = (p % 4 != 0) && (p != 2);
			rx_idle = (p % 4 != 0);
			r = $urandom_range(0, 9);
			plen_w = (r == 0) ? 5'd16 : (r == 1) ? 5'($urandom_range(17, 31)) :
				(r == 2) ? 5'd0 : 5'($urandom_range(1, 5));
			r = $urandom_range(0, 9);
			rlen_w = (r == 0) ? 5'd16 : (r == 1) ? 5'($urandom_range(17, 31)) :
				5'($urandom_range(0, 6));
			for (int k = 0; k < 3; k++) alpha[k] = 8'($urandom);
			for (int k = 0; k < 16; k++) begin
				pat[k] = alpha[$urandom_range(0, 2)];
				rep[k] = 8'($urandom);
			end
			load_config(plen_w, pat, rlen_w, rep);
			plen = board.eff_plen();
			if (p == 2) hold_req = 1'b1;
			sent = 0;
			while (sent < PHASE_WORDS) begin
				r = $urandom_range(0, 99);
				if (r < 45) n = plen;
				else if (r < 55) n = $urandom_range(1, plen);
				else n = 0;
				if (n > 0) begin
					for (int k = 0; k < n; k++) send_word(pat[k], 1'b1, 1'b0);
					sent += n;
				end else if (r < 80) begin
					send_word(alpha[$urandom_range(0, 2)], 1'b1, 1'b0);
					sent++;
				end else if (r < 88) begin
					send_word(8'($urandom), 1'b1, 1'b0);
					sent++;
				end else if (r < 93) begin
					send_word(alpha[$urandom_range(0, 2)], 1'b1, 1'b1);
					sent++;
				end else if (r < 96) begin
					send_word(8'($urandom), 1'b0, 1'b1);
					sent++;
				end else begin
					send_word(8'($urandom), 1'b0, 1'b0);
				end
			end
			if ($urandom_range(0, 1) == 1) send_word(alpha[0], 1'b1, 1'b1);
			settle();
		end

		if (board.errors == 0 && board.expected_words.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

[stream_find_replace_core.f]
rtl/core/sfr_pkg.sv
rtl/core/sfr_cfg_regs.sv
rtl/core/sfr_window.sv
rtl/core/sfr_emit.sv
rtl/core/stream_find_replace_core.sv
sim/tb.sv
